// ----- hdl/gps_position_moving_average_defines.svh -----
// Assertion macros shared by the checker of the position filter.
`ifndef GPS_POSITION_MOVING_AVERAGE_DEFINES_SVH
`define GPS_POSITION_MOVING_AVERAGE_DEFINES_SVH

// Checked at every clock edge outside reset.
`define GPMA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("gpma: assertion failed");

// Checked at every clock edge, reset included.
`define GPMA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("gpma: assertion failed");

`endif

// ----- hdl/gpma_pkg.sv -----
`default_nettype none

package gpma_pkg;

  localparam int unsigned LatW     = 31;
  localparam int unsigned LonW     = 32;
  localparam int unsigned AgeW     = 16;
  localparam int unsigned WinLenW  = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Command queue between the front and the back.
  localparam int unsigned CmdDepth = 2;
  // Queue entries, the item in the back and the output register.
  localparam int unsigned MaxOutstanding = CmdDepth + 2;

  localparam logic [WinLenW-1:0] WindowLengthReset = 6'd5;
  localparam logic [AgeW-1:0]    MaxFixAgeReset    = 16'd2000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWindowLength = 2'd0,
    CfgMaxFixAge    = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [LatW-1:0] sample_lat;
    logic signed [LonW-1:0] sample_lon;
    logic                   location_valid;
    logic [AgeW-1:0]        fix_age_ms;
  } gpma_in_t;

  typedef struct packed {
    logic signed [LatW-1:0] filtered_lat;
    logic signed [LonW-1:0] filtered_lon;
    logic                   fix_ok;
  } gpma_out_t;

  typedef struct packed {
    logic [LatW-1:0] lat;
    logic [LonW-1:0] lon;
    logic            take;
  } gpma_cmd_t;

  typedef struct packed {
    logic               clear;
    logic [WinLenW-1:0] window_length;
  } gpma_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/gps_position_moving_average.sv -----
// Channel   | Direction | Handshake          | Beat
// ----------+-----------+--------------------+-----------------------------------------
// samples   | in        | push / full        | in_i: lat, lon, valid flag, fix age
// results   | out       | pop / empty        | out_o: averaged lat, lon, fix flag
// config    | in        | cfg_valid/cfg_ready| cfg_index_i, cfg_data_i
//
// An accepted sample steps through fetch, update, start, divide and done, the divide
// set by the two bit-serial dividers that run one quotient bit per cycle; a rejected
// sample goes from idle to done. Reset is asynchronous and clears the sums, counters
// and held averages; the ring memory is not cleared since it is always filled before
// use. A two-entry command queue lets samples arrive while the back end is dividing,
// and a finished result waits in an output register without blocking the divide.
`default_nettype none

module gps_position_moving_average #(
  parameter int unsigned MAX_WINDOW = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  gpma_pkg::gpma_in_t              in_i,
  output logic                            empty,
  input  logic                            pop,
  output gpma_pkg::gpma_out_t             out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gpma_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [gpma_pkg::CfgDataW-1:0]   cfg_data_i
);
  import gpma_pkg::*;

  logic [WinLenW-1:0] window_q, window_d;
  logic [AgeW-1:0]    max_age_q, max_age_d;
  logic               cfg_write;
  gpma_ctl_t          ctl;
  logic               cmd_valid, cmd_pop;
  gpma_cmd_t          cmd;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    window_d  = window_q;
    max_age_d = max_age_q;
    if (cfg_write && (cfg_index_i == CfgWindowLength)) begin
      window_d = cfg_data_i[WinLenW-1:0];
    end
    if (cfg_write && (cfg_index_i == CfgMaxFixAge)) begin
      max_age_d = cfg_data_i[AgeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= WindowLengthReset;
      max_age_q <= MaxFixAgeReset;
    end else begin
      window_q  <= window_d;
      max_age_q <= max_age_d;
    end
  end

  assign ctl.clear         = cfg_write && (cfg_index_i == CfgWindowLength);
  assign ctl.window_length = window_q;

  gpma_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .in_i          (in_i),
    .max_fix_age_i (max_age_q),
    .cmd_valid_o   (cmd_valid),
    .cmd_pop_i     (cmd_pop),
    .cmd_o         (cmd)
  );

  gpma_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ----- hdl/gpma_front.sv -----
`default_nettype none

module gpma_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  gpma_pkg::gpma_in_t            in_i,
  input  logic [gpma_pkg::AgeW-1:0]     max_fix_age_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_pop_i,
  output gpma_pkg::gpma_cmd_t           cmd_o
);
  import gpma_pkg::*;

  localparam int unsigned PtrW = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CntW = $clog2(CmdDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(CmdDepth - 1);

  gpma_cmd_t       slots_q [CmdDepth];
  gpma_cmd_t       entry;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  // A sample is classified here: it enters the filter only when the
  // receiver flags it valid and the fix is younger than the limit.
  always_comb begin
    entry.lat  = in_i.sample_lat;
    entry.lon  = in_i.sample_lon;
    entry.take = in_i.location_valid && (in_i.fix_age_ms < max_fix_age_i);
  end

  assign full_o      = (count_q == CntW'(CmdDepth));
  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = slots_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/gpma_div.sv -----
`default_nettype none

module gpma_div #(
  parameter int unsigned DvdW = 38,
  parameter int unsigned DvsW = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0]        divisor_i,
  output logic                   busy_o,
  output logic signed [DvdW-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(DvdW + 1);

  logic [DvdW-1:0]  acc_q, acc_d;
  logic [DvsW-1:0]  rem_q, rem_d, dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [StepW-1:0] step_q, step_d;
  logic [DvsW:0]    trial;
  logic [DvsW:0]    diff;

  // Restoring division on the magnitude, one quotient bit per cycle; the
  // sign is put back at the end so the quotient truncates toward zero.
  assign trial = {rem_q, acc_q[DvdW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    step_d = step_q;
    if (start_i) begin
      neg_d  = dividend_i[DvdW-1];
      acc_d  = dividend_i[DvdW-1] ? (~dividend_i) + DvdW'(1) : dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      step_d = StepW'(DvdW);
    end else if (step_q != '0) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DvsW-1:0];
        acc_d = {acc_q[DvdW-2:0], 1'b1};
      end else begin
        rem_d = trial[DvsW-1:0];
        acc_d = {acc_q[DvdW-2:0], 1'b0};
      end
      step_d = step_q - StepW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign busy_o     = (step_q != '0);
  assign quotient_o = neg_q ? signed'((~acc_q) + DvdW'(1)) : signed'(acc_q);

endmodule

`default_nettype wire

// ----- hdl/gpma_back.sv -----
`default_nettype none

module gpma_back #(
  parameter int unsigned MAX_WINDOW = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gpma_pkg::gpma_ctl_t  ctl_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_pop_o,
  input  gpma_pkg::gpma_cmd_t  cmd_i,
  output logic                 empty_o,
  input  logic                 pop_i,
  output gpma_pkg::gpma_out_t  out_o
);
  import gpma_pkg::*;

  localparam int unsigned CntW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SlotW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned SumW   = LonW + CntW + 1;
  localparam int unsigned EntryW = LatW + LonW;
  localparam int unsigned WideW  = WinLenW + 1;
  localparam logic [WideW-1:0] MaxWinWide = WideW'(MAX_WINDOW);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StFetch  = 6'b000010,
    StUpdate = 6'b000100,
    StStart  = 6'b001000,
    StDivide = 6'b010000,
    StDone   = 6'b100000
  } state_e;

  state_e           state_q, state_d;
  gpma_cmd_t        cmd_q, cmd_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             full_q, full_d;
  logic [SumW-1:0]  lat_sum_q, lat_sum_d, lon_sum_q, lon_sum_d;
  logic [LatW-1:0]  held_lat_q, held_lat_d;
  logic [LonW-1:0]  held_lon_q, held_lon_d;
  gpma_out_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [EntryW-1:0] ring_mem [MAX_WINDOW];
  logic [EntryW-1:0] ring_rd_q;
  logic              ring_access;

  logic [WideW-1:0]       win_len_wide, win_wide;
  logic [CntW-1:0]        win;
  logic [SlotW-1:0]       slot_use, slot_next;
  logic [CntW-1:0]        next_ext;
  logic                   div_start, lat_busy, lon_busy;
  logic signed [SumW-1:0] lat_quot, lon_quot;

  // Effective window: the register clamped to one through the maximum.
  always_comb begin
    win_len_wide = {1'b0, ctl_i.window_length};
    if (win_len_wide == '0) begin
      win_wide = WideW'(1);
    end else if (win_len_wide > MaxWinWide) begin
      win_wide = MaxWinWide;
    end else begin
      win_wide = win_len_wide;
    end
    win = CntW'(win_wide);
  end

  // A write pointer left beyond a shrunken window restarts at slot zero.
  always_comb begin
    slot_use  = (CntW'(slot_q) >= win) ? '0 : slot_q;
    next_ext  = CntW'(slot_use) + CntW'(1);
    slot_next = (next_ext >= win) ? '0 : SlotW'(next_ext);
  end

  assign ring_access = (state_q == StFetch);

  always_ff @(posedge clk_i) begin
    if (ring_access) begin
      ring_mem[slot_use] <= {cmd_q.lat, cmd_q.lon};
      ring_rd_q          <= ring_mem[slot_use];
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    fill_d      = fill_q;
    slot_d      = slot_q;
    full_d      = full_q;
    lat_sum_d   = lat_sum_q;
    lon_sum_d   = lon_sum_q;
    held_lat_d  = held_lat_q;
    held_lon_d  = held_lon_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !pop_i;
    cmd_pop_o   = 1'b0;
    div_start   = 1'b0;

    case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = cmd_i.take ? StFetch : StDone;
        end
      end
      StFetch: begin
        full_d    = !(fill_q < win);
        fill_d    = (fill_q < win) ? fill_q + CntW'(1) : fill_q;
        slot_d    = slot_next;
        lat_sum_d = lat_sum_q + {{(SumW-LatW){cmd_q.lat[LatW-1]}}, cmd_q.lat};
        lon_sum_d = lon_sum_q + {{(SumW-LonW){cmd_q.lon[LonW-1]}}, cmd_q.lon};
        state_d   = StUpdate;
      end
      StUpdate: begin
        // With the window full, the sample being overwritten leaves the sums.
        if (full_q) begin
          lat_sum_d = lat_sum_q
                    - {{(SumW-LatW){ring_rd_q[EntryW-1]}}, ring_rd_q[EntryW-1:LonW]};
          lon_sum_d = lon_sum_q
                    - {{(SumW-LonW){ring_rd_q[LonW-1]}}, ring_rd_q[LonW-1:0]};
        end
        state_d = StStart;
      end
      StStart: begin
        div_start = 1'b1;
        state_d   = StDivide;
      end
      StDivide: begin
        if (!lat_busy && !lon_busy) begin
          held_lat_d = lat_quot[LatW-1:0];
          held_lon_d = lon_quot[LonW-1:0];
          state_d    = StDone;
        end
      end
      StDone: begin
        if (!out_valid_q || pop_i) begin
          out_d.filtered_lat = held_lat_q;
          out_d.filtered_lon = held_lon_q;
          out_d.fix_ok       = cmd_q.take;
          out_valid_d        = 1'b1;
          state_d            = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // A window write empties the filter but keeps the held averages.
    if (ctl_i.clear) begin
      fill_d    = '0;
      slot_d    = '0;
      lat_sum_d = '0;
      lon_sum_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      slot_q      <= '0;
      full_q      <= 1'b0;
      lat_sum_q   <= '0;
      lon_sum_q   <= '0;
      held_lat_q  <= '0;
      held_lon_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      slot_q      <= slot_d;
      full_q      <= full_d;
      lat_sum_q   <= lat_sum_d;
      lon_sum_q   <= lon_sum_d;
      held_lat_q  <= held_lat_d;
      held_lon_q  <= held_lon_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    out_q <= out_d;
  end

  gpma_div #(
    .DvdW (SumW),
    .DvsW (CntW)
  ) u_lat_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (signed'(lat_sum_q)),
    .divisor_i  (fill_q),
    .busy_o     (lat_busy),
    .quotient_o (lat_quot)
  );

  gpma_div #(
    .DvdW (SumW),
    .DvsW (CntW)
  ) u_lon_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (signed'(lon_sum_q)),
    .divisor_i  (fill_q),
    .busy_o     (lon_busy),
    .quotient_o (lon_quot)
  );

  assign empty_o = !out_valid_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire

// ----- hdl/gpma_chk.sv -----
`default_nettype none
`include "gps_position_moving_average_defines.svh"

module gpma_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 push,
  input logic                 full,
  input logic                 pop,
  input logic                 empty,
  input gpma_pkg::gpma_out_t  out_o
);
  import gpma_pkg::*;

  localparam int unsigned OutW = $clog2(MaxOutstanding + 1);

  logic [OutW-1:0]        outstanding_q, outstanding_d;
  logic signed [LatW-1:0] last_lat_q;
  logic signed [LonW-1:0] last_lon_q;

  always_comb begin
    outstanding_d = outstanding_q;
    if ((push && !full) && !(pop && !empty)) begin
      outstanding_d = outstanding_q + OutW'(1);
    end else if (!(push && !full) && (pop && !empty)) begin
      outstanding_d = outstanding_q - OutW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
      last_lat_q    <= '0;
      last_lon_q    <= '0;
    end else begin
      outstanding_q <= outstanding_d;
      if (pop && !empty) begin
        last_lat_q <= out_o.filtered_lat;
        last_lon_q <= out_o.filtered_lon;
      end
    end
  end

  `GPMA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> empty && !full)

  // Samples in flight never exceed the queue, the back end and the output slot.
  `GPMA_ASSERT(a_outstanding, (outstanding_q <= OutW'(MaxOutstanding)) && (empty || (outstanding_q != '0)))

  // A result without a fix repeats the averages of the result before it.
  `GPMA_ASSERT(a_held_on_reject, !empty && !out_o.fix_ok |-> (out_o.filtered_lat == last_lat_q) && (out_o.filtered_lon == last_lon_q))

  `GPMA_ASSERT(a_result_holds, !empty && !pop |=> !empty && $stable(out_o))

endmodule

bind gps_position_moving_average gpma_chk u_gpma_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .push   (push),
  .full   (full),
  .pop    (pop),
  .empty  (empty),
  .out_o  (out_o)
);

`default_nettype wire

// ----- verif/tb.sv -----
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gpma_pkg::*;

  localparam int unsigned MaxWindow   = 20;
  localparam int unsigned GapMax      = 6;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 60;

  // Indexes past the register list; the block must ignore writes to them.
  localparam logic [CfgIdxW-1:0] CfgSpareLow  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareHigh = 2'd3;

  localparam longint LatMin = -64'sd1073741824;
  localparam longint LatMax = 64'sd1073741823;
  localparam longint LonMin = -64'sd2147483648;
  localparam longint LonMax = 64'sd2147483647;

  class fix_filter_scoreboard;
    logic [WinLenW-1:0] window_len;
    logic [AgeW-1:0]    age_limit;
    longint             lat_ring[MaxWindow];
    longint             lon_ring[MaxWindow];
    longint             lat_sum, lon_sum, lat_held, lon_held;
    int unsigned        filled, slot_next;
    gpma_out_t          pending_q[$];
    int unsigned        errors, samples, fixes, reg_writes, beats;

    function new();
      window_len = WindowLengthReset;
      age_limit  = MaxFixAgeReset;
      lat_held   = 0;
      lon_held   = 0;
      errors     = 0;
      samples    = 0;
      fixes      = 0;
      reg_writes = 0;
      beats      = 0;
      empty_window();
    endfunction

    function void empty_window();
      filled    = 0;
      slot_next = 0;
      lat_sum   = 0;
      lon_sum   = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      reg_writes++;
      if (idx == CfgWindowLength) begin
        // Any window write restarts warm-up but keeps the held averages.
        window_len = data[WinLenW-1:0];
        empty_window();
      end else if (idx == CfgMaxFixAge) begin
        age_limit = data;
      end
    endfunction

    function void note_sample(gpma_in_t s);
      longint      lat, lon;
      int unsigned win, slot;
      bit          take;
      gpma_out_t   res;
      lat  = longint'($signed(s.sample_lat));
      lon  = longint'($signed(s.sample_lon));
      take = s.location_valid && (s.fix_age_ms < age_limit);
      samples++;
      if (take) begin
        win  = (window_len == 0) ? 1 : ((window_len > MaxWindow) ? MaxWindow : window_len);
        slot = (slot_next >= win) ? 0 : slot_next;
        if (filled < win) begin
          filled++;
        end else begin
          lat_sum -= lat_ring[slot];
          lon_sum -= lon_ring[slot];
        end
        lat_ring[slot] = lat;
        lon_ring[slot] = lon;
        lat_sum += lat;
        lon_sum += lon;
        slot_next = (slot + 1 >= win) ? 0 : slot + 1;
        lat_held = lat_sum / longint'(filled);
        lon_held = lon_sum / longint'(filled);
        fixes++;
      end
      res.filtered_lat = lat_held[LatW-1:0];
      res.filtered_lon = lon_held[LonW-1:0];
      res.fix_ok       = take;
      pending_q.push_back(res);
    endfunction

    task report(string what);
      $display("tb: result beat %0d: %s", beats, what);
      errors++;
    endtask

    task check_result(gpma_out_t got);
      gpma_out_t want;
      beats++;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected beat lat=%h lon=%h fix=%b",
                         got.filtered_lat, got.filtered_lon, got.fix_ok));
      end else begin
        want = pending_q.pop_front();
        if (got.filtered_lat !== want.filtered_lat)
          report($sformatf("filtered_lat %h, want %h", got.filtered_lat, want.filtered_lat));
        if (got.filtered_lon !== want.filtered_lon)
          report($sformatf("filtered_lon %h, want %h", got.filtered_lon, want.filtered_lon));
        if (got.fix_ok !== want.fix_ok)
          report($sformatf("fix_ok %b, want %b", got.fix_ok, want.fix_ok));
      end
    endtask
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b1;
  logic                push        = 1'b0;
  logic                full;
  gpma_in_t            in_i        = '0;
  logic                empty;
  logic                pop         = 1'b0;
  gpma_out_t           out_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  fix_filter_scoreboard sb;
  bit          steady = 1'b0;
  longint      walk_lat, walk_lon;
  int unsigned cycles = 0;

  gps_position_moving_average #(
    .MAX_WINDOW(MaxWindow)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_i       (in_i),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, GapMax);
  endfunction

  function automatic longint fit(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic gpma_in_t mk(longint lat, longint lon, bit valid, int unsigned age);
    gpma_in_t s;
    s.sample_lat     = lat[LatW-1:0];
    s.sample_lon     = lon[LonW-1:0];
    s.location_valid = valid;
    s.fix_age_ms     = age[AgeW-1:0];
    return s;
  endfunction

  // Mostly a slowly drifting track of good fixes; the rest is stale, invalid
  // or fully random samples.
  function automatic gpma_in_t random_sample();
    int unsigned     pick;
    logic [LatW-1:0] lat_bits;
    logic [LonW-1:0] lon_bits;
    int unsigned     limit;
    pick     = $urandom_range(0, 99);
    lat_bits = $urandom;
    lon_bits = $urandom;
    limit    = sb.age_limit;
    if (pick < 4) begin
      case ($urandom_range(0, 2))
        0: begin walk_lat = LatMin; walk_lon = LonMin; end
        1: begin walk_lat = LatMax; walk_lon = LonMax; end
        default: begin
          walk_lat = longint'($signed(lat_bits));
          walk_lon = longint'($signed(lon_bits));
        end
      endcase
    end
    if (pick < 85) begin
      walk_lat = fit(walk_lat + longint'($urandom_range(0, 4000)) - 2000, LatMin, LatMax);
      walk_lon = fit(walk_lon + longint'($urandom_range(0, 4000)) - 2000, LonMin, LonMax);
      return mk(walk_lat, walk_lon, 1'b1, (limit == 0) ? 0 : $urandom_range(0, limit - 1));
    end
    case ($urandom_range(0, 2))
      0: return mk(walk_lat, walk_lon, 1'b0, $urandom_range(0, 65535));
      1: return mk(walk_lat, walk_lon, 1'b1, $urandom_range(limit, 65535));
      default: return mk(longint'($signed(lat_bits)), longint'($signed(lon_bits)),
                         $urandom_range(0, 1), $urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_sample(gpma_in_t s);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= s;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_sample(s);
  endtask

  // The block is idle once every expected result has been popped.
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.pending_q.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(logic [CfgDataW-1:0] win_data, logic [AgeW-1:0] age,
                           int unsigned count);
    drain();
    write_reg($urandom_range(0, 1) ? CfgSpareLow : CfgSpareHigh, $urandom);
    write_reg(CfgMaxFixAge, age);
    write_reg(CfgWindowLength, win_data);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        drain();
        case ($urandom_range(0, 2))
          0: write_reg(CfgMaxFixAge, sb.age_limit);
          1: write_reg(CfgWindowLength, {$urandom_range(0, 1023), sb.window_len});
          default: ;
        endcase
      end
      if ($urandom_range(0, 29) == 0) steady = !steady;
      send_sample(random_sample());
    end
  endtask

  initial begin
    forever begin
      int unsigned stall;
      @(posedge clk_i);
      if (rst_ni) begin
        forever begin
          stall = draw_gap();
          if (stall != 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clk_i);
          end
          pop <= 1'b1;
          @(posedge clk_i);
          while (empty) @(posedge clk_i);
          sb.check_result(out_o);
        end
      end
    end
  end

  initial begin
    // The falling edge at time zero resets the block before its first clock.
    rst_ni   <= 1'b0;
    sb       = new();
    walk_lat = 473977000;
    walk_lon = 85414000;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: window of five, age limit of 2000 ms.
    send_sample(mk(LatMax, LonMax, 1'b1, 0));
    send_sample(mk(LatMin, LonMin, 1'b1, 1999));
    send_sample(mk(5, -5, 1'b1, 2000));
    send_sample(mk(7, 7, 1'b0, 0));
    send_sample(mk(-3, 3, 1'b1, 100));
    send_sample(mk(-473977001, -85414003, 1'b1, 10));
    send_sample(mk(473977000, 85414000, 1'b1, 1500));
    send_sample(mk(-7, 11, 1'b1, 0));
    send_sample(mk(899999999, -1799999999, 1'b1, 3));

    drain();
    write_reg(CfgMaxFixAge, 16'd0);
    send_sample(mk(1000, 2000, 1'b1, 0));
    drain();
    write_reg(CfgMaxFixAge, 16'hFFFF);
    send_sample(mk(1000, 2000, 1'b1, 65535));
    send_sample(mk(-1000, -2000, 1'b1, 65534));

    drain();
    write_reg(CfgWindowLength, 16'd0);
    send_sample(mk(LatMin, LonMax, 1'b1, 0));
    send_sample(mk(-9, 9, 1'b1, 0));
    drain();
    write_reg(CfgWindowLength, 16'd0);
    send_sample(mk(0, 0, 1'b0, 0));

    drain();
    write_reg(CfgSpareLow, 16'hFFFF);
    write_reg(CfgSpareHigh, 16'h5A5A);
    write_reg(CfgWindowLength, 16'hFFC0 | 16'd21);
    for (int i = 0; i < 23; i++)
      send_sample(mk((i % 2 == 1) ? LatMin : LatMax, (i % 3 == 0) ? LonMin : LonMax, 1'b1, i));

    run_phase(16'd5, 16'd2000, 100);
    run_phase(16'd1, 16'hFFFF, 100);
    run_phase(16'd20, 16'd1000, 100);
    run_phase(16'd0, 16'd500, 100);
    run_phase(16'hFFFF, 16'hFFFF, 100);
    run_phase(16'd13, 16'd0, 30);
    run_phase(16'd2, 16'd3000, 100);
    run_phase(16'd7, 16'hFFFE, 100);
    run_phase(16'd20, 16'd2000, 100);

    drain();
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb: %0d samples, %0d taken into the average, %0d register writes",
             sb.samples, sb.fixes, sb.reg_writes);
    $display("tb: windows 0 to 63 against the clamp at %0d, age limits 0 to 65535, %0d errors",
             MaxWindow, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/gpma_pkg.sv
hdl/gpma_front.sv
hdl/gpma_div.sv
hdl/gpma_back.sv
hdl/gps_position_moving_average.sv
hdl/gpma_chk.sv
verif/tb.sv
